// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled away for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/prvp_pkg.sv =====
// ----------------------------------------------------------------------------
// prvp_pkg
// shared types and constants of the pressure relief valve pulser
// ----------------------------------------------------------------------------
`default_nettype none

package prvp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SET_POINT     = 3'd0;
  localparam logic [2:0] REG_TOLERANCE     = 3'd1;
  localparam logic [2:0] REG_MAX_EXCESS    = 3'd2;
  localparam logic [2:0] REG_MIN_ON_MS     = 3'd3;
  localparam logic [2:0] REG_MAX_OFF_MS    = 3'd4;
  localparam logic [2:0] REG_NORMALLY_OPEN = 3'd5;

  // register reset values
  localparam logic [15:0] MAX_EXCESS_RST = 16'd1000;
  localparam logic [15:0] MIN_ON_MS_RST  = 16'd100;
  localparam logic [15:0] MAX_OFF_MS_RST = 16'd1000;

  // shift-add and shift-subtract steps, one per cycle
  localparam int unsigned STEP_CNT_W = 4;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_LEN  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/pressure_relief_valve_pulser_top.sv =====
// ----------------------------------------------------------------------------
// pressure_relief_valve_pulser_top
// relief valve relay pulser: one pressure sample in, one coil/relay/vent out
// ----------------------------------------------------------------------------
// Each sample passes through these steps from its transfer to a valid result:
// the transfer edge captures the sample and does the band compares, then come
// the shift-add multiply steps (excess * max_off_ms), the restoring divide
// steps by max_excess, the ST_LEN state for the period length and the ST_FIN
// state to commit the relay state and load the result register. All multiply
// and divide steps run on a single shared 18-bit add/subtract unit. The input
// is stalled from the transfer until the state commit, so a new sample is not
// taken before the last one is committed; the commit waits while an earlier
// result is still stalled on the output. Configuration writes are always taken
// (cfg_ready stays high) and are meant for idle time.
`default_nettype none
`include "assert_macros.svh"

module pressure_relief_valve_pulser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // sample channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pressure,
  input  wire logic [31:0] in_now_ms,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_coil_level,
  output logic             out_relay_on,
  output logic             out_venting,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] set_point_r;
  logic [11:0] tolerance_r;
  logic [15:0] max_excess_r;
  logic [15:0] min_on_ms_r;
  logic [15:0] max_off_ms_r;
  logic        normally_open_r;

  // controller state
  prvp_pkg::state_t state_r, state_nxt;
  logic [prvp_pkg::STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic        relay_r, relay_nxt;
  logic        vent_r, vent_nxt;
  logic        run_r, run_nxt;
  logic [31:0] start_r, start_nxt;
  logic [16:0] len_r, len_nxt;

  // per-sample working registers
  logic [31:0] now_r, now_nxt;
  logic [15:0] excess_r, excess_nxt;
  logic        below_r, below_nxt;
  logic        above_r, above_nxt;
  logic        coil_r, coil_nxt;
  logic [31:0] p_r, p_nxt;
  logic [16:0] len_calc_r, len_calc_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_coil_r, out_coil_nxt;
  logic out_relay_r, out_relay_nxt;
  logic out_vent_r, out_vent_nxt;

  logic in_xfer;
  logic out_free;

  // shared add/subtract unit
  logic [16:0] alu_a;
  logic [15:0] alu_b;
  logic        alu_sub;
  logic [17:0] alu_res;

  // commit helpers
  logic [31:0] elapsed;
  logic [16:0] len_lim;

  assign in_stall  = (state_r != prvp_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_coil_level = out_coil_r;
  assign out_relay_on   = out_relay_r;
  assign out_venting    = out_vent_r;

  // operand selection for the shared unit
  always_comb begin
    alu_a   = {1'b0, p_r[31:16]};
    alu_b   = p_r[0] ? excess_r : 16'd0;
    alu_sub = 1'b0;
    if (state_r == prvp_pkg::ST_DIV) begin
      alu_a   = {p_r[31:16], p_r[15]};
      alu_b   = max_excess_r;
      alu_sub = 1'b1;
    end
  end

  assign alu_res = {1'b0, alu_a}
                 + (alu_sub ? ~{2'b00, alu_b} : {2'b00, alu_b})
                 + {17'd0, alu_sub};

  // elapsed time and applicable period length at commit
  assign elapsed = run_r ? (now_r - start_r) : 32'd0;
  assign len_lim = run_r ? len_r : len_calc_r;

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    relay_nxt     = relay_r;
    vent_nxt      = vent_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    now_nxt       = now_r;
    excess_nxt    = excess_r;
    below_nxt     = below_r;
    above_nxt     = above_r;
    coil_nxt      = coil_r;
    p_nxt         = p_r;
    len_calc_nxt  = len_calc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_coil_nxt  = out_coil_r;
    out_relay_nxt = out_relay_r;
    out_vent_nxt  = out_vent_r;

    case (state_r)
      prvp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          // capture sample, band compares and coil from the held relay state
          now_nxt    = in_now_ms;
          excess_nxt = in_pressure - set_point_r;
          below_nxt  = {1'b0, in_pressure} < ({1'b0, set_point_r} + {5'd0, tolerance_r});
          above_nxt  = in_pressure > set_point_r;
          coil_nxt   = relay_r ^ ~normally_open_r;
          p_nxt      = {16'd0, max_off_ms_r};
          cnt_nxt    = '0;
          state_nxt  = prvp_pkg::ST_MUL;
        end
      end
      prvp_pkg::ST_MUL: begin
        // shift-add step, multiplier in the low half
        p_nxt   = {alu_res[16:0], p_r[15:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = prvp_pkg::ST_DIV;
        end
      end
      prvp_pkg::ST_DIV: begin
        // restoring divide step, remainder high, quotient shifts in low
        if (alu_res[17]) begin
          p_nxt = {p_r[30:0], 1'b0};
        end else begin
          p_nxt = {alu_res[15:0], p_r[14:0], 1'b1};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = prvp_pkg::ST_LEN;
        end
      end
      prvp_pkg::ST_LEN: begin
        // period length for a newly started period
        len_calc_nxt = {1'b0, max_off_ms_r} - {1'b0, p_r[15:0]} + {1'b0, min_on_ms_r};
        state_nxt    = prvp_pkg::ST_FIN;
      end
      prvp_pkg::ST_FIN: begin
        if (out_free) begin
          // relay, vent and period update
          if (below_r) begin
            vent_nxt  = 1'b0;
            relay_nxt = 1'b0;
          end else if (above_r) begin
            vent_nxt = 1'b1;
            if (excess_r > max_excess_r) begin
              relay_nxt = 1'b1;
              run_nxt   = 1'b0;
            end else begin
              relay_nxt = run_r ? relay_r : 1'b1;
              run_nxt   = 1'b1;
              if (!run_r) begin
                start_nxt = now_r;
                len_nxt   = len_calc_r;
              end
              if (elapsed > {16'd0, min_on_ms_r}) begin
                relay_nxt = 1'b0;
              end
              if (elapsed > {15'd0, len_lim} || elapsed > {16'd0, max_off_ms_r}) begin
                run_nxt = 1'b0;
              end
            end
          end
          // result register load
          out_valid_nxt = 1'b1;
          out_coil_nxt  = coil_r;
          out_relay_nxt = relay_nxt;
          out_vent_nxt  = vent_nxt;
          state_nxt     = prvp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = prvp_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= prvp_pkg::ST_IDLE;
      cnt_r           <= '0;
      relay_r         <= 1'b0;
      vent_r          <= 1'b0;
      run_r           <= 1'b0;
      start_r         <= '0;
      len_r           <= '0;
      out_valid_r     <= 1'b0;
      set_point_r     <= '0;
      tolerance_r     <= '0;
      max_excess_r    <= prvp_pkg::MAX_EXCESS_RST;
      min_on_ms_r     <= prvp_pkg::MIN_ON_MS_RST;
      max_off_ms_r    <= prvp_pkg::MAX_OFF_MS_RST;
      normally_open_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      relay_r     <= relay_nxt;
      vent_r      <= vent_nxt;
      run_r       <= run_nxt;
      start_r     <= start_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      // configuration write transfer, unknown indexes ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          prvp_pkg::REG_SET_POINT:     set_point_r     <= cfg_data;
          prvp_pkg::REG_TOLERANCE:     tolerance_r     <= cfg_data[11:0];
          prvp_pkg::REG_MAX_EXCESS:    max_excess_r    <= cfg_data;
          prvp_pkg::REG_MIN_ON_MS:     min_on_ms_r     <= cfg_data;
          prvp_pkg::REG_MAX_OFF_MS:    max_off_ms_r    <= cfg_data;
          prvp_pkg::REG_NORMALLY_OPEN: normally_open_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    excess_r    <= excess_nxt;
    below_r     <= below_nxt;
    above_r     <= above_nxt;
    coil_r      <= coil_nxt;
    p_r         <= p_nxt;
    len_calc_r  <= len_calc_nxt;
    out_coil_r  <= out_coil_nxt;
    out_relay_r <= out_relay_nxt;
    out_vent_r  <= out_vent_nxt;
  end

  // assertions
  `ASSERT_NXT(a_xfer_starts_mul, clk, rst_n, in_xfer, state_r == prvp_pkg::ST_MUL)
  `ASSERT_IMP(a_idle_cnt_clear, clk, rst_n, state_r == prvp_pkg::ST_IDLE, cnt_r == '0)
  `ASSERT_IMP(a_no_relay_unvented, clk, rst_n, out_valid_r && !out_vent_r, !out_relay_r)

endmodule

`default_nettype wire
